// ===== hdl/vdt_pkg.sv =====
// Shared constants and the beat record that travels down the cell chain.
// No dependencies; imported by every module of the vector dominance table.
`default_nettype none
package vdt_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int MAX_DIMS    = 16;
	localparam int VALUE_WIDTH = 8;

	localparam int IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int POS_W = $clog2(MAX_DIMS + 1);

	// start-to-done distance: front register, one stage per cell, result register
	localparam int LATENCY = MAX_ENTRIES + 2;

	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic                   valid;
		logic                   first;      // component index zero
		logic                   in_dims;    // index below MAX_DIMS
		logic [IDX_W-1:0]       idx;
		logic [VALUE_WIDTH-1:0] value;
		logic                   last;
		logic                   action;
		logic                   nonzero;    // running: some component nonzero
		logic                   overlength; // running: past MAX_DIMS
		logic                   claimed;    // a free cell was passed
		logic                   dominated;  // a stored entry is <= query
	} beat_t;

endpackage
`default_nettype wire

// ===== hdl/vdt_front.sv =====
// Input stage: tracks the component position and per-vector flags, and
// launches one beat per accepted item into the cell chain. Uses vdt_pkg.
`default_nettype none
module vdt_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           accept,
	input  wire logic                           action,
	input  wire logic [vdt_pkg::VALUE_WIDTH-1:0] element_value,
	input  wire logic                           is_last,
	output vdt_pkg::beat_t                      beat_o
);
	import vdt_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic             nz_q;
	logic             ovl_q;
	beat_t            beat_q;

	logic in_dims;
	logic nonzero;
	logic overlength;

	assign in_dims    = pos_q < POS_W'(MAX_DIMS);
	assign nonzero    = nz_q | (in_dims & (element_value != '0));
	assign overlength = ovl_q | ~in_dims;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			nz_q   <= 1'b0;
			ovl_q  <= 1'b0;
			beat_q <= '0;
		end else begin
			beat_q.valid <= accept;
			if (accept) begin
				beat_q.first      <= pos_q == '0;
				beat_q.in_dims    <= in_dims;
				beat_q.idx        <= pos_q[IDX_W-1:0];
				beat_q.value      <= element_value;
				beat_q.last       <= is_last;
				beat_q.action     <= action;
				beat_q.nonzero    <= nonzero;
				beat_q.overlength <= overlength;
				beat_q.claimed    <= 1'b0;
				beat_q.dominated  <= 1'b0;
				if (is_last) begin
					pos_q <= '0;
					nz_q  <= 1'b0;
					ovl_q <= 1'b0;
				end else begin
					if (in_dims) begin
						pos_q <= pos_q + POS_W'(1);
					end
					nz_q  <= nonzero;
					ovl_q <= overlength;
				end
			end
		end
	end

	assign beat_o = beat_q;

endmodule
`default_nettype wire

// ===== hdl/vdt_cell.sv =====
// One table entry: its stored vector, valid flag and dominance bit. Updates
// from the passing beat and registers the beat for the next cell. Uses vdt_pkg.
`default_nettype none
module vdt_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire vdt_pkg::beat_t beat_i,
	output vdt_pkg::beat_t      beat_o
);
	import vdt_pkg::*;

	logic [VALUE_WIDTH-1:0] comp_q [MAX_DIMS];
	logic                   valid_q;
	logic                   dom_q;
	beat_t                  beat_q;

	logic  le;
	logic  dom_next;
	logic  tail_nz;
	logic  free_hit;
	logic  capture;
	logic  commit;
	beat_t beat_d;

	always_comb begin
		le       = comp_q[beat_i.idx] <= beat_i.value;
		dom_next = beat_i.in_dims ? ((beat_i.first | dom_q) & le) : dom_q;
		// stored components past the query's end compare against zero
		tail_nz  = 1'b0;
		for (int d = 0; d < MAX_DIMS; d++) begin
			if (beat_i.in_dims && (IDX_W'(d) > beat_i.idx) && (comp_q[d] != '0)) begin
				tail_nz = 1'b1;
			end
		end
		free_hit = beat_i.valid & ~valid_q & ~beat_i.claimed;
		capture  = free_hit & beat_i.in_dims;
		commit   = free_hit & beat_i.last & (beat_i.action == ACT_ADD) & beat_i.nonzero;

		beat_d           = beat_i;
		beat_d.claimed   = beat_i.claimed | ~valid_q;
		beat_d.dominated = beat_i.dominated
			| (beat_i.last & valid_q & dom_next & ~tail_nz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dom_q   <= 1'b1;
			beat_q  <= '0;
		end else begin
			beat_q <= beat_d;
			if (beat_i.valid) begin
				dom_q <= dom_next;
			end
			if (commit) begin
				valid_q <= 1'b1;
			end
		end
	end

	// entry payload, only written while the cell is free; the first
	// component zero fills the rest of the entry
	always_ff @(posedge clk) begin
		if (capture) begin
			for (int d = 0; d < MAX_DIMS; d++) begin
				if (IDX_W'(d) == beat_i.idx) begin
					comp_q[d] <= beat_i.value;
				end else if (beat_i.first) begin
					comp_q[d] <= '0;
				end
			end
		end
	end

	assign beat_o = beat_q;

endmodule
`default_nettype wire

// ===== hdl/vector_dominance_table.sv =====
// Top level of the vector dominance table: front stage, chain of entry
// cells and result register. Depends on vdt_pkg, vdt_front and vdt_cell.
//
// Usage
//   A vector arrives one component per beat: start, action, element_value,
//   is_last. A beat is taken at every rising edge with start high and busy
//   low; busy stays low, so one component can be sent every cycle and
//   vectors can follow each other with no gap.
//   Only the action on the is_last beat counts: add stores the vector into
//   the next free entry when it is nonzero, query reports is_minimal when
//   no stored entry is componentwise <= the vector. Short vectors are zero
//   filled; components past MAX_DIMS are dropped and set length_error.
//   Each beat walks the chain of MAX_ENTRIES cells, one cell per cycle, and
//   every cell compares it against its own entry. done pulses for one cycle
//   with the result once the is_last beat has passed the front register,
//   every cell and the result register. Results leave in order, one per
//   vector, and are never held: the receiver has to take them.
//   Reset empties the table and drops any vector in flight. The table
//   fills in order and is emptied by reset only.
`default_nettype none
module vector_dominance_table (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output wire logic                           busy,
	input  wire logic                           action,
	input  wire logic [vdt_pkg::VALUE_WIDTH-1:0] element_value,
	input  wire logic                           is_last,
	output wire logic                           done,
	output wire logic                           result_kind,
	output wire logic                           is_minimal,
	output wire logic                           accepted,
	output wire logic                           table_full,
	output wire logic                           length_error
);
	import vdt_pkg::*;

	beat_t chain [MAX_ENTRIES+1];

	logic accept;
	logic done_q;
	logic kind_q;
	logic minimal_q;
	logic accepted_q;
	logic full_q;
	logic len_err_q;

	beat_t tail;
	logic  is_add;

	// the chain takes a beat every cycle, no backpressure toward the sender
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	vdt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.action        (action),
		.element_value (element_value),
		.is_last       (is_last),
		.beat_o        (chain[0])
	);

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		vdt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.beat_i (chain[i]),
			.beat_o (chain[i+1])
		);
	end

	assign tail   = chain[MAX_ENTRIES];
	assign is_add = tail.action == ACT_ADD;

	// result register: the end of the chain decides add and query outcomes.
	// claimed on the last beat means a free entry took the vector.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tail.valid & tail.last;
		end
	end

	always_ff @(posedge clk) begin
		kind_q     <= tail.action;
		minimal_q  <= (tail.action == ACT_QUERY) & ~tail.dominated;
		accepted_q <= is_add & tail.nonzero & tail.claimed;
		full_q     <= is_add & tail.nonzero & ~tail.claimed;
		len_err_q  <= tail.overlength;
	end

	assign done         = done_q;
	assign result_kind  = kind_q;
	assign is_minimal   = minimal_q;
	assign accepted     = accepted_q;
	assign table_full   = full_q;
	assign length_error = len_err_q;

endmodule
`default_nettype wire

// ===== hdl/vdt_checker.sv =====
// Port-level checks on the vector dominance table and the bind that
// attaches them to the top level. Uses vdt_pkg.
`default_nettype none
module vdt_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic action,
	input wire logic is_last,
	input wire logic done,
	input wire logic result_kind,
	input wire logic is_minimal,
	input wire logic accepted,
	input wire logic table_full
);
	import vdt_pkg::*;

	a_done_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && is_last, LATENCY))
		else $error("done without a last beat at the chain latency");

	a_kind_matches_action: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result_kind == $past(action, LATENCY))
		else $error("result kind differs from the action of the last beat");

	a_add_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		done && result_kind == ACT_ADD |-> !is_minimal && !(accepted && table_full))
		else $error("inconsistent add result");

	a_query_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		done && result_kind == ACT_QUERY |-> !accepted && !table_full)
		else $error("query result carries add flags");

endmodule

bind vector_dominance_table vdt_checker u_vdt_checker (.*);
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for vector_dominance_table: directed rows, then random vectors.
// Results are checked against a table predictor or typed answers; depends on vdt_pkg and the RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import vdt_pkg::*;

	localparam int TOTAL_BEATS    = 1950;
	localparam int MAX_GAP        = 12;
	// longest quiet stretch of a correct run is the closing wait, longer than one full trip down the chain
	localparam int WATCHDOG_LIMIT = 8 * (LATENCY + MAX_GAP + 4);
	localparam int REPORT_LIMIT   = 10;
	localparam int VALUE_MAX      = (1 << VALUE_WIDTH) - 1;

	// one result beat, field by field
	typedef struct packed {
		logic kind;
		logic minimal;
		logic accepted;
		logic full;
		logic length_err;
	} answer_t;

	// one row of the directed table; typed rows carry a hand-written answer
	typedef struct {
		logic                   act;
		logic [VALUE_WIDTH-1:0] value;
		logic                   tail;
		bit                     typed;
		answer_t                want;
	} stim_row_t;

	logic                   clk;
	logic                   arst_n        = 1'b0;
	logic                   start         = 1'b0;
	logic                   action        = ACT_ADD;
	logic [VALUE_WIDTH-1:0] element_value = '0;
	logic                   is_last       = 1'b0;
	logic                   busy;
	logic                   done;
	logic                   result_kind;
	logic                   is_minimal;
	logic                   accepted;
	logic                   table_full;
	logic                   length_error;

	vector_dominance_table dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.element_value(element_value),
		.is_last      (is_last),
		.done         (done),
		.result_kind  (result_kind),
		.is_minimal   (is_minimal),
		.accepted     (accepted),
		.table_full   (table_full),
		.length_error (length_error)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Predictor: own copy of the entry table and of the vector being
	// assembled. Entries fill in order, so rows_used bounds every scan.
	// ---------------------------------------------------------------
	logic [VALUE_WIDTH-1:0] table_rows [MAX_ENTRIES][MAX_DIMS];
	int                     rows_used = 0;
	logic [VALUE_WIDTH-1:0] partial [MAX_DIMS];
	int                     part_pos = 0;
	bit                     part_nonzero = 1'b0;
	bit                     part_overlong = 1'b0;

	answer_t answers_due [$];

	// stats and error counts
	int beats_sent   = 0;
	int vectors_sent = 0;
	int burst_left   = 0;
	int mismatches   = 0;
	int unexpected   = 0;
	int quiet_cycles = 0;
	int n_stored     = 0;
	int n_dropped    = 0;
	int n_zero_adds  = 0;
	int n_queries    = 0;
	int n_minimal    = 0;
	int n_overlength = 0;

	initial begin
		for (int d = 0; d < MAX_DIMS; d++)
			partial[d] = '0;
	end

	// append one expected result beat at the back of the queue
	function automatic void queue_answer(input answer_t a);
		answers_due = {answers_due, a};
	endfunction

	// Takes one component beat. On the tail beat the action of that beat
	// alone decides: query scans every used entry, add stores a nonzero vector while an entry is free.
	function automatic void fold_component(input logic act, input logic [VALUE_WIDTH-1:0] value,
			input logic tail, output bit produced, output answer_t res);
		bit covers;
		produced = 1'b0;
		res      = '0;
		if (part_pos < MAX_DIMS) begin
			partial[part_pos] = value;
			if (value != 0)
				part_nonzero = 1'b1;
			part_pos++;
		end else begin
			// components past the dimension are dropped but flagged
			part_overlong = 1'b1;
		end
		if (!tail)
			return;
		produced       = 1'b1;
		res.kind       = act;
		res.length_err = part_overlong;
		if (act == ACT_QUERY) begin
			// unsent components are zero in partial, so the scan covers all dims
			res.minimal = 1'b1;
			for (int i = 0; i < rows_used; i++) begin
				covers = 1'b1;
				for (int d = 0; d < MAX_DIMS; d++)
					if (table_rows[i][d] > partial[d])
						covers = 1'b0;
				if (covers)
					res.minimal = 1'b0;
			end
		end else if (part_nonzero) begin
			if (rows_used < MAX_ENTRIES) begin
				for (int d = 0; d < MAX_DIMS; d++)
					table_rows[rows_used][d] = partial[d];
				rows_used++;
				res.accepted = 1'b1;
			end else begin
				res.full = 1'b1;
			end
		end
		for (int d = 0; d < MAX_DIMS; d++)
			partial[d] = '0;
		part_pos      = 0;
		part_nonzero  = 1'b0;
		part_overlong = 1'b0;
	endfunction

	// ---------------------------------------------------------------
	// Sender. A beat is held until an edge with busy low takes it; the
	// start line then either stays high (inside a burst) or drops for a
	// random gap, which can land anywhere inside a vector.
	// ---------------------------------------------------------------
	task automatic send_beat(input logic act, input logic [VALUE_WIDTH-1:0] value,
			input logic tail, input bit typed, input answer_t want);
		bit      produced;
		answer_t res;
		start         <= 1'b1;
		action        <= act;
		element_value <= value;
		is_last       <= tail;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		beats_sent++;
		fold_component(act, value, tail, produced, res);
		if (produced) begin
			queue_answer(typed ? want : res);
			vectors_sent++;
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
			// now and then a long stretch with no gaps at all
			burst_left = ($urandom_range(0, 99) < 15) ? $urandom_range(100, 300)
			                                          : $urandom_range(0, 20);
		end
	endtask

	// hold off until every outstanding answer has come back
	task automatic drain_answers();
		start <= 1'b0;
		@(posedge clk);
		while (answers_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic stim_row_t row(input logic act, input int value, input logic tail);
		stim_row_t r;
		r.act   = act;
		r.value = value[VALUE_WIDTH-1:0];
		r.tail  = tail;
		r.typed = 1'b0;
		r.want  = '0;
		return r;
	endfunction

	function automatic stim_row_t row_typed(input logic act, input int value, input logic minimal,
			input logic acc, input logic full, input logic lerr);
		stim_row_t r;
		r       = row(act, value, 1'b1);
		r.typed = 1'b1;
		r.want  = '{kind: act, minimal: minimal, accepted: acc, full: full, length_err: lerr};
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Result checker and watchdog. Results cannot be held off, so every
	// done cycle is one result beat.
	// ---------------------------------------------------------------
	answer_t seen;
	answer_t oldest;

	always @(posedge clk) begin
		if (arst_n && done) begin
			seen = '{kind: result_kind, minimal: is_minimal, accepted: accepted,
			         full: table_full, length_err: length_error};
			if (answers_due.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= REPORT_LIMIT)
					$display("[%0t] result beat with nothing expected: %b", $realtime, seen);
			end else begin
				oldest = answers_due.pop_front();
				if (seen !== oldest) begin
					mismatches++;
					if (mismatches + unexpected <= REPORT_LIMIT)
						$display("[%0t] kind/minimal/accepted/full/length_err exp %b%b%b%b%b got %b%b%b%b%b",
						         $realtime, oldest.kind, oldest.minimal, oldest.accepted,
						         oldest.full, oldest.length_err, seen.kind, seen.minimal,
						         seen.accepted, seen.full, seen.length_err);
				end
				if (oldest.kind == ACT_QUERY) begin
					n_queries++;
					if (oldest.minimal)
						n_minimal++;
				end else if (oldest.accepted) begin
					n_stored++;
				end else if (oldest.full) begin
					n_dropped++;
				end else begin
					n_zero_adds++;
				end
				if (oldest.length_err)
					n_overlength++;
			end
		end
		if (!arst_n || (start && !busy) || done)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: %0d cycles without a beat", quiet_cycles);
			$display("vector_dominance_table: mismatch");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	stim_row_t directed [$];

	// append one row at the end of the directed table
	function automatic void add_row(input stim_row_t r);
		directed = {directed, r};
	endfunction

	initial begin
		int                     len;
		int                     src;
		int                     v;
		logic                   tail_act;
		logic [VALUE_WIDTH-1:0] comp [MAX_DIMS + 8];
		answer_t                blank;

		blank = '0;

		// empty table: any query is minimal, zero add is refused quietly
		add_row(row_typed(ACT_QUERY, 0, 1'b1, 1'b0, 1'b0, 1'b0));
		add_row(row_typed(ACT_ADD, 0, 1'b0, 1'b0, 1'b0, 1'b0));
		// top value stored, then hit exactly and just missed
		add_row(row_typed(ACT_ADD, VALUE_MAX, 1'b0, 1'b1, 1'b0, 1'b0));
		add_row(row_typed(ACT_QUERY, VALUE_MAX, 1'b0, 1'b0, 1'b0, 1'b0));
		add_row(row_typed(ACT_QUERY, VALUE_MAX - 1, 1'b1, 1'b0, 1'b0, 1'b0));
		// action on a non-tail beat is ignored
		add_row(row(ACT_QUERY, 1, 1'b0));
		add_row(row(ACT_ADD, 2, 1'b1));
		// over-length zero vector: dropped component flagged, nothing stored
		for (int k = 0; k < MAX_DIMS; k++)
			add_row(row((k % 2) ? ACT_QUERY : ACT_ADD, 0, 1'b0));
		add_row(row_typed(ACT_ADD, VALUE_MAX, 1'b0, 1'b0, 1'b0, 1'b1));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		burst_left = $urandom_range(0, 20);
		foreach (directed[n])
			send_beat(directed[n].act, directed[n].value, directed[n].tail,
			          directed[n].typed, directed[n].want);
		drain_answers();

		// Random part. Adds are a minority so the table fills partway
		// through, leaving room for queries on a partial and a full table.
		while (beats_sent < TOTAL_BEATS) begin
			v = $urandom_range(0, 99);
			if (v < 8)
				len = $urandom_range(MAX_DIMS + 1, MAX_DIMS + 4);
			else if (v < 20)
				len = MAX_DIMS;
			else
				len = $urandom_range(1, MAX_DIMS);
			tail_act = ($urandom_range(0, 99) < 35) ? ACT_ADD : ACT_QUERY;

			if (tail_act == ACT_QUERY && rows_used > 0 && $urandom_range(0, 2) == 0) begin
				// near a stored entry: mostly dominated, a small dip makes a near miss
				src = $urandom_range(0, rows_used - 1);
				if (len < MAX_DIMS)
					len = MAX_DIMS;
				for (int d = 0; d < len; d++) begin
					v = (d < MAX_DIMS) ? int'(table_rows[src][d]) : $urandom_range(0, VALUE_MAX);
					if ($urandom_range(0, 3) == 0)
						v += $urandom_range(0, 2);
					if (v > 0 && $urandom_range(0, 15) == 0)
						v--;
					comp[d] = (v > VALUE_MAX) ? VALUE_MAX[VALUE_WIDTH-1:0] : v[VALUE_WIDTH-1:0];
				end
			end else begin
				// sparse small components so dominance goes both ways
				for (int d = 0; d < len; d++) begin
					v = $urandom_range(0, 99);
					if (v < 50)
						comp[d] = '0;
					else if (v < 85)
						comp[d] = VALUE_WIDTH'($urandom_range(1, 3));
					else
						comp[d] = VALUE_WIDTH'($urandom_range(0, VALUE_MAX));
				end
			end

			for (int k = 0; k < len; k++)
				send_beat((k == len - 1) ? tail_act : logic'($urandom_range(0, 1)),
				          comp[k], k == len - 1, 1'b0, blank);

			if (vectors_sent % 47 == 0)
				drain_answers();
		end

		// wind down: all answers back, then one more chain trip for strays
		drain_answers();
		repeat (LATENCY + 8) @(posedge clk);

		$display("%0d beats, %0d vectors: %0d stored, %0d dropped on full table, %0d zero adds",
		         beats_sent, vectors_sent, n_stored, n_dropped, n_zero_adds);
		$display("%0d queries (%0d minimal), %0d over-length vectors, %0d entries in use",
		         n_queries, n_minimal, n_overlength, rows_used);
		if (mismatches == 0 && unexpected == 0 && answers_due.size() == 0) begin
			$display("vector_dominance_table: match");
		end else begin
			$display("%0d wrong, %0d unexpected, %0d missing",
			         mismatches, unexpected, answers_due.size());
			$display("vector_dominance_table: mismatch");
		end
		$finish;
	end

endmodule
